>>> src/uart_baud_divisor_calc_macros.svh
`ifndef UART_BAUD_DIVISOR_CALC_MACROS_SVH
`define UART_BAUD_DIVISOR_CALC_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define UBDC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define UBDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ubdc_pkg.sv
package ubdc_pkg;

    localparam int CLK_W     = 28;
    localparam int BAUD_W    = 24;
    localparam int NUM_W     = 33;
    localparam int DEN_W     = 26;
    localparam int REM_W     = DEN_W + 1;
    localparam int QUO_W     = NUM_W;
    localparam int NUM_CELLS = QUO_W;
    localparam int WORD_W    = 16;
    localparam int STAT_W    = 2;
    localparam int S_DATA_W  = 56;
    localparam int M_DATA_W  = 24;

    localparam int DIV100_W    = 19;
    localparam int MANT_W      = 12;
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 26;
    localparam int FRAC_W      = 11;
    localparam int FRAC_SHIFT  = 17;
    localparam int REMD_W      = 7;

    localparam logic [QUO_W-1:0]    MANT_SAT_LIMIT = 33'd409600;
    localparam logic [RECIP_W-1:0]  RECIP_100      = 20'd671089;
    localparam logic [FRAC_W-1:0]   FRAC_RECIP     = 11'd1311;
    localparam logic [FRAC_W-1:0]   ROUND_HALF     = 11'd50;
    localparam logic [DIV100_W-1:0] HUNDRED        = 19'd100;
    localparam logic [WORD_W-1:0]   WORD_SAT_BY8   = 16'hFFF7;
    localparam logic [WORD_W-1:0]   WORD_SAT_BY16  = 16'hFFFF;

    localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_ZERO = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_SAT  = 2'd2;

    typedef struct packed {
        logic             valid;
        logic             baud_zero;
        logic             by8;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic [DEN_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } ubdc_div_t;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] word;
        logic [STAT_W-1:0] status;
    } ubdc_res_t;

endpackage

>>> src/ubdc_div_cell.sv
module ubdc_div_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  ubdc_pkg::ubdc_div_t din,
    output ubdc_pkg::ubdc_div_t dout
);

    logic [ubdc_pkg::REM_W-1:0] shifted;
    logic [ubdc_pkg::REM_W:0]   diff;
    logic                       ge;
    ubdc_pkg::ubdc_div_t        dout_reg;
    ubdc_pkg::ubdc_div_t        dout_next;

    always_comb
    begin
        shifted   = {din.rem, din.num[ubdc_pkg::NUM_W-1]};
        diff      = {1'b0, shifted} - {2'b00, din.den};
        ge        = !diff[ubdc_pkg::REM_W];
        dout_next = din;
        dout_next.num = {din.num[ubdc_pkg::NUM_W-2:0], 1'b0};
        dout_next.quo = {din.quo[ubdc_pkg::QUO_W-2:0], ge};
        dout_next.rem = ge ? diff[ubdc_pkg::DEN_W-1:0] : shifted[ubdc_pkg::DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout_reg <= '0;
        end
        else if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

>>> src/ubdc_post.sv
module ubdc_post
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  ubdc_pkg::ubdc_div_t din,
    output ubdc_pkg::ubdc_res_t dout
);

    typedef struct packed {
        logic                          valid;
        logic                          baud_zero;
        logic                          sat;
        logic                          by8;
        logic [ubdc_pkg::DIV100_W-1:0] div100;
        logic [ubdc_pkg::MANT_W-1:0]   mant;
    } p1_t;

    typedef struct packed {
        logic                        valid;
        logic                        baud_zero;
        logic                        sat;
        logic                        by8;
        logic [ubdc_pkg::MANT_W-1:0] mant;
        logic [ubdc_pkg::FRAC_W-1:0] scaled;
    } p2_t;

    localparam int PROD_W  = ubdc_pkg::DIV100_W + ubdc_pkg::RECIP_W;
    localparam int FPROD_W = 2 * ubdc_pkg::FRAC_W;
    localparam int FRQ_W   = FPROD_W - ubdc_pkg::FRAC_SHIFT;

    logic [PROD_W-1:0]              prod;
    logic [ubdc_pkg::DIV100_W-1:0]  mant_x100;
    logic [ubdc_pkg::DIV100_W-1:0]  rem_full;
    logic [ubdc_pkg::REMD_W-1:0]    rem;
    logic [FPROD_W-1:0]             fprod;
    logic [FRQ_W-1:0]               frac_q;
    logic [FRQ_W-1:0]               steps;
    logic                           carry;
    logic [ubdc_pkg::MANT_W:0]      mant_c;
    logic [3:0]                     frac_c;
    p1_t                            p1_reg;
    p1_t                            p1_next;
    p2_t                            p2_reg;
    p2_t                            p2_next;
    ubdc_pkg::ubdc_res_t            res_reg;
    ubdc_pkg::ubdc_res_t            res_next;

    always_comb
    begin
        prod = {{ubdc_pkg::RECIP_W{1'b0}}, din.quo[ubdc_pkg::DIV100_W-1:0]}
             * {{ubdc_pkg::DIV100_W{1'b0}}, ubdc_pkg::RECIP_100};
        p1_next.valid     = din.valid;
        p1_next.baud_zero = din.baud_zero;
        p1_next.sat       = din.quo >= ubdc_pkg::MANT_SAT_LIMIT;
        p1_next.by8       = din.by8;
        p1_next.div100    = din.quo[ubdc_pkg::DIV100_W-1:0];
        p1_next.mant      = prod[ubdc_pkg::RECIP_SHIFT+ubdc_pkg::MANT_W-1:ubdc_pkg::RECIP_SHIFT];
    end

    always_comb
    begin
        mant_x100 = {{(ubdc_pkg::DIV100_W-ubdc_pkg::MANT_W){1'b0}}, p1_reg.mant}
                  * ubdc_pkg::HUNDRED;
        rem_full  = p1_reg.div100 - mant_x100;
        rem       = rem_full[ubdc_pkg::REMD_W-1:0];
        p2_next.valid     = p1_reg.valid;
        p2_next.baud_zero = p1_reg.baud_zero;
        p2_next.sat       = p1_reg.sat;
        p2_next.by8       = p1_reg.by8;
        p2_next.mant      = p1_reg.mant;
        p2_next.scaled    = (p1_reg.by8 ? {1'b0, rem, 3'b000} : {rem, 4'b0000})
                          + ubdc_pkg::ROUND_HALF;
    end

    always_comb
    begin
        fprod  = {{ubdc_pkg::FRAC_W{1'b0}}, p2_reg.scaled}
               * {{ubdc_pkg::FRAC_W{1'b0}}, ubdc_pkg::FRAC_RECIP};
        frac_q = fprod[FPROD_W-1:ubdc_pkg::FRAC_SHIFT];
        steps  = p2_reg.by8 ? FRQ_W'(8) : FRQ_W'(16);
        carry  = frac_q >= steps;
        mant_c = {1'b0, p2_reg.mant} + {{ubdc_pkg::MANT_W{1'b0}}, carry};
        frac_c = carry ? 4'd0 : frac_q[3:0];
        res_next.valid = p2_reg.valid;
        priority if (p2_reg.baud_zero)
        begin
            res_next.word   = '0;
            res_next.status = ubdc_pkg::STATUS_ZERO;
        end
        else if (p2_reg.sat || mant_c[ubdc_pkg::MANT_W])
        begin
            res_next.word   = p2_reg.by8 ? ubdc_pkg::WORD_SAT_BY8 : ubdc_pkg::WORD_SAT_BY16;
            res_next.status = ubdc_pkg::STATUS_SAT;
        end
        else
        begin
            res_next.word   = {mant_c[ubdc_pkg::MANT_W-1:0], frac_c};
            res_next.status = ubdc_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg  <= '0;
            p2_reg  <= '0;
            res_reg <= '0;
        end
        else if (en)
        begin
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
            res_reg <= res_next;
        end
    end

    assign dout = res_reg;

endmodule

>>> src/uart_baud_divisor_calc.sv
// UART fractional baud divisor calculator.
// Input stream s_*: one transfer carries clock_hz, baud_rate and oversample_by_8.
// Output stream m_*: one transfer per input carries divisor_word and status_code
// (0 ok, 1 baud rate zero, 2 mantissa saturated at 4095).
// The divider 25*clock/(2 or 4 * baud) runs through a row of 33 restoring cells,
// one quotient bit per cell; three more stages split mantissa and fraction,
// round the fraction and pack the word.
// Throughput: one transfer per cycle while the skid register is empty; every cell
// and stage moves together on the shared enable and holds while it is full.
// s_tready depends only on a one-entry skid register behind the output
// register, never combinationally on m_tready.
// When m_tready is low the output holds, the skid register takes the next
// finished result, and then the whole row stalls and s_tready drops until
// the output drains.
// Reset clears all valid flags; no items are in flight afterward.
`include "uart_baud_divisor_calc_macros.svh"

module uart_baud_divisor_calc
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [27:0] clock_hz, [51:28] baud_rate, [52] oversample_by_8, [55:53] zero
    input  logic [ubdc_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [15:0] divisor_word, [17:16] status_code, [23:18] zero
    output logic [ubdc_pkg::M_DATA_W-1:0] m_tdata
);

    logic [ubdc_pkg::CLK_W-1:0]  clock_hz;
    logic [ubdc_pkg::BAUD_W-1:0] baud_rate;
    logic                        oversample_by_8;
    logic [ubdc_pkg::NUM_W-1:0]  clk_ext;
    logic                        en;
    logic                        incoming;
    ubdc_pkg::ubdc_div_t         chain [ubdc_pkg::NUM_CELLS+1];
    ubdc_pkg::ubdc_res_t         post_out;

    logic                          out_valid_reg;
    logic [ubdc_pkg::WORD_W-1:0]   out_word_reg;
    logic [ubdc_pkg::STAT_W-1:0]   out_status_reg;
    logic                          skid_valid_reg;
    logic [ubdc_pkg::WORD_W-1:0]   skid_word_reg;
    logic [ubdc_pkg::STAT_W-1:0]   skid_status_reg;

    assign clock_hz        = s_tdata[ubdc_pkg::CLK_W-1:0];
    assign baud_rate       = s_tdata[ubdc_pkg::CLK_W+ubdc_pkg::BAUD_W-1:ubdc_pkg::CLK_W];
    assign oversample_by_8 = s_tdata[ubdc_pkg::CLK_W+ubdc_pkg::BAUD_W];
    assign clk_ext = {{(ubdc_pkg::NUM_W-ubdc_pkg::CLK_W){1'b0}}, clock_hz};

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    always_comb
    begin
        chain[0].valid     = s_tvalid;
        chain[0].baud_zero = baud_rate == '0;
        chain[0].by8       = oversample_by_8;
        chain[0].num       = (clk_ext << 4) + (clk_ext << 3) + clk_ext;
        chain[0].den       = oversample_by_8 ? {1'b0, baud_rate, 1'b0} : {baud_rate, 2'b00};
        chain[0].rem       = '0;
        chain[0].quo       = '0;
    end

    for (genvar i = 0; i < ubdc_pkg::NUM_CELLS; i++)
    begin : g_cell
        ubdc_div_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .din   (chain[i]),
            .dout  (chain[i+1])
        );
    end

    ubdc_post u_post
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (chain[ubdc_pkg::NUM_CELLS]),
        .dout  (post_out)
    );

    assign incoming = en && post_out.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            out_word_reg    <= '0;
            out_status_reg  <= '0;
            skid_valid_reg  <= 1'b0;
            skid_word_reg   <= '0;
            skid_status_reg <= '0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                out_word_reg   <= skid_word_reg;
                out_status_reg <= skid_status_reg;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= incoming;
                if (incoming)
                begin
                    out_word_reg   <= post_out.word;
                    out_status_reg <= post_out.status;
                end
            end
        end
        else if (incoming)
        begin
            skid_valid_reg  <= 1'b1;
            skid_word_reg   <= post_out.word;
            skid_status_reg <= post_out.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(ubdc_pkg::M_DATA_W-ubdc_pkg::WORD_W-ubdc_pkg::STAT_W){1'b0}},
                       out_status_reg, out_word_reg};

    `UBDC_ASSERT_SAME(a_skid_fill, clk, rst_n, $rose(skid_valid_reg),
                      $past(out_valid_reg && !m_tready),
                      "skid filled without a stalled output")
    `UBDC_ASSERT_NEXT(a_skid_drain, clk, rst_n, skid_valid_reg && m_tready,
                      !skid_valid_reg, "skid did not drain")
    `UBDC_ASSERT_SAME(a_status_code, clk, rst_n, out_valid_reg,
                      out_status_reg == ubdc_pkg::STATUS_OK
                      || out_status_reg == ubdc_pkg::STATUS_ZERO
                      || out_status_reg == ubdc_pkg::STATUS_SAT,
                      "bad status code")
    `UBDC_ASSERT_SAME(a_zero_word, clk, rst_n,
                      out_valid_reg && out_status_reg == ubdc_pkg::STATUS_ZERO,
                      out_word_reg == '0, "zero baud with nonzero word")

endmodule
